// ===== src/msbc_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and helpers for the msbc h2 deframer
package msbc_pkg;

    localparam int PAYLOAD_BYTES_DEF = 57;

    // h2 header bytes
    localparam logic [7:0] H2_SYNC     = 8'h01;
    localparam logic [7:0] H2_SYNCWORD = 8'had;
    localparam logic [7:0] H2_SEQ0     = 8'h08;
    localparam logic [7:0] H2_SEQ1     = 8'h38;
    localparam logic [7:0] H2_SEQ2     = 8'hc8;
    localparam logic [7:0] H2_SEQ3     = 8'hf8;

    // output word layout, lowest bit first
    localparam int OD_BYTE_LO   = 0;
    localparam int OD_SEQ_LO    = 8;
    localparam int OD_LOST_LO   = 10;
    localparam int OD_TLOST_LO  = 12;
    localparam int OD_TSKIP_LO  = 44;
    localparam int OD_TFRAME_LO = 76;
    localparam int OUT_FIELDS_W = 108;
    localparam int OUT_TDATA_W  = 112;

    // skip amounts
    localparam logic [1:0] SKIP_NONE = 2'd0;
    localparam logic [1:0] SKIP_ONE  = 2'd1;
    localparam logic [1:0] SKIP_TWO  = 2'd2;

    typedef struct packed {
        logic [1:0] skip_amt;
        logic       set_seq;
        logic       store;
        logic       frame_done;
        logic       idx_inc;
        logic       idx_clr;
        logic       rd_en;
        logic       load_out;
    } msbc_cmd_t;

    typedef struct packed {
        logic is_sync;
        logic is_zero;
        logic is_code;
        logic is_syncword;
        logic idx_last;
        logic out_free;
    } msbc_status_t;

    // saturating 32-bit add of a small increment
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [1:0] b);
        logic [32:0] sum;
        begin
            sum = {1'b0, a} + {31'b0, b};
            return sum[32] ? 32'hffff_ffff : sum[31:0];
        end
    endfunction

endpackage

// ===== src/msbc_h2_deframer_unit.sv =====
`timescale 1ns / 1ps
// top level of the msbc h2 header deframer
//
// takes raw link bytes one word at a time on the s_axis side and hunts for an h2 header
// (0x01, one of the sequence codes 0x08/0x38/0xc8/0xf8, then the syncword 0xad); zero
// padding between frames is ignored, any other stray byte adds to the skipped total
// (one for a bad hunt byte or bad sequence code, two for a missing syncword), and a
// fresh 0x01 restarts the hunt at once. the syncword and the following payload bytes,
// PAYLOAD_BYTES in all, are kept in an on-chip memory; once the last one is in, the
// frame is played out on the m_axis side as PAYLOAD_BYTES words with tlast on the final
// one, each word also carrying the sequence number, the frames lost since the previous
// frame (modulo 4, zero for the first frame) and the saturating 32-bit totals of lost
// frames, skipped bytes and delivered frames as they stand after this frame.
// rate: while hunting or filling, one input word per cycle. during play-out s_axis_tready
// is low; every output word is a memory read, then an output register load that waits
// out any m_axis back-pressure, as the payload memory has a single registered read port.
// the input reopens as soon as the last word sits in the output register.
module msbc_h2_deframer_unit #(
    parameter int PAYLOAD_BYTES = msbc_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // in_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // frame_byte[7:0], sequence_number[9:8], lost_frames[11:10], total_lost[43:12],
    // total_skipped[75:44], total_frames[107:76], zero[111:108]
    output logic [msbc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tlast   // last_of_frame
);

    msbc_pkg::msbc_cmd_t    cmd;
    msbc_pkg::msbc_status_t status;

    // header hunt and play-out sequencing
    msbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // payload store, statistics and output register
    msbc_datapath #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_last  (m_axis_tlast),
        .out_data  (m_axis_tdata)
    );

    // a non-final word of a frame in the output register means play-out is running
    a_no_input_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input open while a frame is being played out");

    // every delivered word belongs to a counted frame
    a_frame_counted: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[msbc_pkg::OD_TFRAME_LO +: 32] != 32'd0))
        else $error("output word with zero frame total");

    // the sequence and lost fields stay fixed from one word of a run to the next
    a_seq_steady: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid
        |-> m_axis_tdata[msbc_pkg::OD_SEQ_LO +: 4]
            == $past(m_axis_tdata[msbc_pkg::OD_SEQ_LO +: 4]))
        else $error("sequence or lost count changed within a frame");

endmodule

// ===== src/msbc_ctrl.sv =====
`timescale 1ns / 1ps
// header hunt and frame play-out controller
module msbc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  msbc_pkg::msbc_status_t status,
    output msbc_pkg::msbc_cmd_t    cmd
);

    localparam logic [2:0] ST_HUNT = 3'd0;
    localparam logic [2:0] ST_SEQ  = 3'd1;
    localparam logic [2:0] ST_WORD = 3'd2;
    localparam logic [2:0] ST_PAY  = 3'd3;
    localparam logic [2:0] ST_RD   = 3'd4;
    localparam logic [2:0] ST_LD   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_HUNT) || (state_reg == ST_SEQ)
                   || (state_reg == ST_WORD) || (state_reg == ST_PAY);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_HUNT:
            begin
                if (accept)
                begin
                    if (status.is_sync)
                        state_next = ST_SEQ;
                    else if (!status.is_zero)
                        cmd.skip_amt = msbc_pkg::SKIP_ONE;
                end
            end
            ST_SEQ:
            begin
                if (accept)
                begin
                    if (status.is_code)
                    begin
                        cmd.set_seq = 1'b1;
                        state_next  = ST_WORD;
                    end
                    else
                    begin
                        cmd.skip_amt = msbc_pkg::SKIP_ONE;
                        state_next   = status.is_sync ? ST_SEQ : ST_HUNT;
                    end
                end
            end
            ST_WORD:
            begin
                if (accept)
                begin
                    if (status.is_syncword)
                    begin
                        cmd.store   = 1'b1;
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_PAY;
                    end
                    else
                    begin
                        cmd.skip_amt = msbc_pkg::SKIP_TWO;
                        state_next   = status.is_sync ? ST_SEQ : ST_HUNT;
                    end
                end
            end
            ST_PAY:
            begin
                if (accept)
                begin
                    cmd.store = 1'b1;
                    if (status.idx_last)
                    begin
                        cmd.frame_done = 1'b1;
                        cmd.idx_clr    = 1'b1;
                        state_next     = ST_RD;
                    end
                    else
                        cmd.idx_inc = 1'b1;
                end
            end
            ST_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LD;
            end
            ST_LD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (status.idx_last)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_HUNT;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_HUNT;
        else
            state_reg <= state_next;
    end

endmodule

// ===== src/msbc_datapath.sv =====
`timescale 1ns / 1ps
// byte decode, payload memory, frame statistics and output register
module msbc_datapath #(
    parameter int PAYLOAD_BYTES = msbc_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [7:0]                          in_byte,
    input  msbc_pkg::msbc_cmd_t                 cmd,
    output msbc_pkg::msbc_status_t              status,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic                                out_last,
    output logic [msbc_pkg::OUT_TDATA_W-1:0]    out_data
);

    localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAYLOAD_BYTES - 1);

    logic [7:0]       mem [PAYLOAD_BYTES];
    logic [7:0]       rd_data_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [1:0]       seq_reg;
    logic [1:0]       prev_seq_reg;
    logic             prev_valid_reg;
    logic [1:0]       lost_reg;
    logic [31:0]      lost_total_reg;
    logic [31:0]      skip_total_reg;
    logic [31:0]      frame_total_reg;
    logic             out_valid_reg;
    logic             out_last_reg;
    logic [msbc_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic [1:0] code_seq;
    logic       code_hit;
    logic [1:0] lost_next;

    always_comb
    begin
        code_hit = 1'b1;
        code_seq = 2'd0;
        unique case (in_byte)
            msbc_pkg::H2_SEQ0: code_seq = 2'd0;
            msbc_pkg::H2_SEQ1: code_seq = 2'd1;
            msbc_pkg::H2_SEQ2: code_seq = 2'd2;
            msbc_pkg::H2_SEQ3: code_seq = 2'd3;
            default:           code_hit = 1'b0;
        endcase
    end

    assign lost_next = prev_valid_reg ? (seq_reg - prev_seq_reg - 2'd1) : 2'd0;

    assign status.is_sync     = (in_byte == msbc_pkg::H2_SYNC);
    assign status.is_zero     = (in_byte == 8'h00);
    assign status.is_code     = code_hit;
    assign status.is_syncword = (in_byte == msbc_pkg::H2_SYNCWORD);
    assign status.idx_last    = (idx_reg == IDX_LAST);
    assign status.out_free    = !out_valid_reg || out_ready;

    // payload memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.store)
            mem[idx_reg] <= in_byte;
        if (cmd.rd_en)
            rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            seq_reg         <= '0;
            prev_seq_reg    <= '0;
            prev_valid_reg  <= 1'b0;
            lost_reg        <= '0;
            lost_total_reg  <= '0;
            skip_total_reg  <= '0;
            frame_total_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + IDX_W'(1);
            if (cmd.set_seq)
                seq_reg <= code_seq;
            if (cmd.skip_amt != msbc_pkg::SKIP_NONE)
                skip_total_reg <= msbc_pkg::sat_add(skip_total_reg, cmd.skip_amt);
            if (cmd.frame_done)
            begin
                lost_reg        <= lost_next;
                lost_total_reg  <= msbc_pkg::sat_add(lost_total_reg, lost_next);
                frame_total_reg <= msbc_pkg::sat_add(frame_total_reg, 2'd1);
                prev_seq_reg    <= seq_reg;
                prev_valid_reg  <= 1'b1;
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // output word contents
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_last_reg <= status.idx_last;
            out_data_reg <= msbc_pkg::OUT_TDATA_W'({frame_total_reg, skip_total_reg,
                                                    lost_total_reg, lost_reg, seq_reg,
                                                    rd_data_reg});
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the msbc h2 header deframer
module tb_top;

    localparam int PAYLOAD    = msbc_pkg::PAYLOAD_BYTES_DEF;
    localparam int TDATA_W    = msbc_pkg::OUT_TDATA_W;
    localparam int STALL_MAX  = 1000;  // cycles with no word moving on either side
    localparam int TAIL_WAIT  = 2 * PAYLOAD + 20;
    localparam int RANDOM_LEN = 80;    // least number of link bytes in the random stretch

    // one expected output word of a delivered frame
    typedef struct {
        logic [7:0]  data;
        logic        is_last;
        logic [1:0]  seq;
        logic [1:0]  lost;
        logic [31:0] lost_sum;
        logic [31:0] skip_sum;
        logic [31:0] frame_sum;
    } frame_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = 8'h00;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tlast;

    // deframer model state
    int          hunt_fill = 0;
    logic [7:0]  payload_buf [PAYLOAD];
    logic [1:0]  rx_seq = 2'd0;
    logic [1:0]  last_seq = 2'd0;
    logic        last_seq_ok = 1'b0;
    logic [31:0] lost_sum = '0;
    logic [31:0] skip_sum = '0;
    logic [31:0] frame_sum = '0;

    frame_word_t frame_word_q [$];

    int errors = 0;
    int sent_bytes = 0;
    int words_seen = 0;
    int frames_seen = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit calm = 1'b0;  // no idling on either side once set

    always #5 clk = ~clk;

    msbc_h2_deframer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic logic [31:0] sat_inc(input logic [31:0] a, input int unsigned inc);
        logic [32:0] s;
        s = {1'b0, a} + 33'(inc);
        return s[32] ? 32'hffff_ffff : s[31:0];
    endfunction

    // sequence number for a header code, -1 when the byte is no code
    function automatic int code_to_seq(input logic [7:0] b);
        case (b)
            msbc_pkg::H2_SEQ0: return 0;
            msbc_pkg::H2_SEQ1: return 1;
            msbc_pkg::H2_SEQ2: return 2;
            msbc_pkg::H2_SEQ3: return 3;
            default:           return -1;
        endcase
    endfunction

    function automatic logic [7:0] seq_to_code(input logic [1:0] s);
        case (s)
            2'd0:    return msbc_pkg::H2_SEQ0;
            2'd1:    return msbc_pkg::H2_SEQ1;
            2'd2:    return msbc_pkg::H2_SEQ2;
            default: return msbc_pkg::H2_SEQ3;
        endcase
    endfunction

    // advance the header hunt by one link byte; a finished frame queues its words
    task automatic absorb_link_byte(input logic [7:0] b);
        int          seq;
        logic [1:0]  lost;
        frame_word_t w;
        seq = code_to_seq(b);
        lost = 2'd0;
        if (hunt_fill == 0)
        begin
            // padding zeros pass silently, other stray bytes count as skipped
            if (b == msbc_pkg::H2_SYNC)
                hunt_fill = 1;
            else if (b != 8'h00)
                skip_sum = sat_inc(skip_sum, 1);
        end
        else if (hunt_fill == 1)
        begin
            if (seq < 0)
            begin
                skip_sum = sat_inc(skip_sum, 1);
                hunt_fill = (b == msbc_pkg::H2_SYNC) ? 1 : 0;
            end
            else
            begin
                rx_seq = seq[1:0];
                hunt_fill = 2;
            end
        end
        else if (hunt_fill == 2 && b != msbc_pkg::H2_SYNCWORD)
        begin
            // header thrown away: sync and code both counted
            skip_sum = sat_inc(skip_sum, 2);
            hunt_fill = (b == msbc_pkg::H2_SYNC) ? 1 : 0;
        end
        else
        begin
            payload_buf[hunt_fill - 2] = b;
            hunt_fill++;
            if (hunt_fill == 2 + PAYLOAD)
            begin
                if (last_seq_ok)
                    lost = rx_seq - last_seq - 2'd1;
                last_seq = rx_seq;
                last_seq_ok = 1'b1;
                lost_sum = sat_inc(lost_sum, lost);
                frame_sum = sat_inc(frame_sum, 1);
                hunt_fill = 0;
                for (int k = 0; k < PAYLOAD; k++)
                begin
                    w.data      = payload_buf[k];
                    w.is_last   = (k == PAYLOAD - 1);
                    w.seq       = rx_seq;
                    w.lost      = lost;
                    w.lost_sum  = lost_sum;
                    w.skip_sum  = skip_sum;
                    w.frame_sum = frame_sum;
                    frame_word_q.push_back(w);
                end
            end
        end
    endtask

    // offer one link byte, with a random gap first unless the run is calm
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        absorb_link_byte(b);
        sent_bytes++;
    endtask

    // full frame; a marked frame carries sync, zero, all-ones and syncword in its payload
    task automatic send_frame(input logic [1:0] seq, input bit marked);
        send_byte(msbc_pkg::H2_SYNC);
        send_byte(seq_to_code(seq));
        send_byte(msbc_pkg::H2_SYNCWORD);
        for (int j = 1; j < PAYLOAD; j++)
        begin
            if (marked && j == 1)
                send_byte(msbc_pkg::H2_SYNC);
            else if (marked && j == 2)
                send_byte(8'h00);
            else if (marked && j == 3)
                send_byte(8'hff);
            else if (marked && j == 4)
                send_byte(msbc_pkg::H2_SYNCWORD);
            else
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endtask

    // padding, stray bytes and every way a header can break
    task automatic test_header_errors();
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h80);
        send_byte(8'h7f);
        send_byte(8'h02);
        send_byte(msbc_pkg::H2_SYNC);      // sync then sync: bad code, stays after sync
        send_byte(msbc_pkg::H2_SYNC);
        send_byte(msbc_pkg::H2_SEQ0);
        send_byte(8'h00);                  // missing syncword, back to hunting
        send_byte(msbc_pkg::H2_SYNC);
        send_byte(8'hff);                  // bad code, back to hunting
        send_byte(msbc_pkg::H2_SYNC);
        send_byte(msbc_pkg::H2_SEQ1);
        send_byte(msbc_pkg::H2_SYNC);      // missing syncword that restarts the header
        send_byte(8'h55);
        send_byte(msbc_pkg::H2_SYNC);
        send_byte(msbc_pkg::H2_SEQ3);
        send_byte(8'hae);
        send_byte(8'h00);
    endtask

    // every sequence code at least once, with a jump, a repeat and a step back for the lost count
    task automatic test_each_sequence();
        send_frame(2'd0, 1'b1);
        send_frame(2'd1, 1'b0);
        send_frame(2'd3, 1'b1);
        send_frame(2'd3, 1'b0);
        send_frame(2'd2, 1'b0);
    endtask

    // mostly good frames with random content, mixed with broken headers and noise
    task automatic test_random_stream();
        int start;
        int n;
        start = sent_bytes;
        while (sent_bytes - start < RANDOM_LEN)
        begin
            case ($urandom_range(0, 9))
                7:
                begin
                    send_byte(msbc_pkg::H2_SYNC);
                    send_byte(8'($urandom_range(0, 255)));
                end
                8:
                begin
                    send_byte(msbc_pkg::H2_SYNC);
                    send_byte(seq_to_code(2'($urandom_range(0, 3))));
                    send_byte(8'($urandom_range(0, 255)));
                end
                9:
                begin
                    n = $urandom_range(1, 4);
                    repeat (n)
                        send_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
                end
                default: send_frame(2'($urandom_range(0, 3)), 1'b0);
            endcase
        end
    endtask

    // closing stretch with both sides running flat out
    task automatic test_back_to_back();
        calm = 1'b1;
        send_frame(2'($urandom_range(0, 3)), 1'b1);
        send_byte(8'h00);
        send_frame(2'($urandom_range(0, 3)), 1'b0);
    endtask

    // output side back-pressure in random bursts
    always @(negedge clk)
    begin
        if (calm)
            m_axis_tready <= 1'b1;
        else if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // output check against the oldest queued word, plus the no-progress watchdog
    always @(posedge clk)
    begin
        frame_word_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_seen++;
            if (frame_word_q.size() == 0)
            begin
                errors++;
                $display("%0t: word with nothing expected, got %0h", $time, m_axis_tdata);
            end
            else
            begin
                w = frame_word_q.pop_front();
                compare_field("frame_byte", 32'(w.data),
                              32'(m_axis_tdata[msbc_pkg::OD_BYTE_LO +: 8]));
                compare_field("tlast", 32'(w.is_last), 32'(m_axis_tlast));
                compare_field("sequence", 32'(w.seq),
                              32'(m_axis_tdata[msbc_pkg::OD_SEQ_LO +: 2]));
                compare_field("lost_frames", 32'(w.lost),
                              32'(m_axis_tdata[msbc_pkg::OD_LOST_LO +: 2]));
                compare_field("total_lost", w.lost_sum,
                              m_axis_tdata[msbc_pkg::OD_TLOST_LO +: 32]);
                compare_field("total_skipped", w.skip_sum,
                              m_axis_tdata[msbc_pkg::OD_TSKIP_LO +: 32]);
                compare_field("total_frames", w.frame_sum,
                              m_axis_tdata[msbc_pkg::OD_TFRAME_LO +: 32]);
                compare_field("pad bits", 32'd0,
                              32'(m_axis_tdata[TDATA_W-1:msbc_pkg::OUT_FIELDS_W]));
                if (w.is_last)
                    frames_seen++;
            end
        end
        if (!rst_n || (m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == STALL_MAX)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_header_errors();
        test_each_sequence();
        test_random_stream();
        test_back_to_back();

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (frame_word_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        $display("sent %0d link bytes; %0d frames and %0d payload words checked",
                 sent_bytes, frames_seen, words_seen);
        $display("bytes skipped %0d, frames lost %0d", skip_sum, lost_sum);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== msbc_h2_deframer_unit.f =====
src/msbc_pkg.sv
src/msbc_ctrl.sv
src/msbc_datapath.sv
src/msbc_h2_deframer_unit.sv
tb/tb_top.sv
